FILE: rtl/cpe_pkg.sv
`default_nettype none

package cpe_pkg;

    localparam int unsigned IDX_W = 6;

    localparam logic [7:0]  SEQ_TAG    = 8'h30;
    localparam logic [23:0] WIN_MATCH  = 24'h034200;
    localparam logic [7:0]  LAST_MATCH = 8'h04;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SEARCH = 2'd1,
        PH_COPY   = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_PENDING  = 3'd0,
        ST_FOUND    = 3'd1,
        ST_INVALID  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_TRUNC    = 3'd4
    } status_t;

    typedef struct packed {
        logic             has_key;
        logic [7:0]       key_byte;
        logic [IDX_W-1:0] key_index;
        status_t          status;
        logic             final_flag;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/cpe_parse.sv
`default_nettype none

module cpe_parse #(
    parameter int KEY_BYTES = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      data_byte,
    input  wire logic            end_of_cert,
    output logic                 res_valid,
    output cpe_pkg::result_t     res
);
    import cpe_pkg::*;

    phase_t             phase_reg,  phase_next;
    logic [23:0]        window_reg, window_next;
    logic [IDX_W-1:0]   count_reg,  count_next;

    logic               win_hit;
    logic               last_key;

    assign win_hit  = (window_reg == WIN_MATCH) && (data_byte == LAST_MATCH);
    assign last_key = ({1'b0, count_reg} + 7'd1) >= 7'(KEY_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            window_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        count_next  = count_reg;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (data_byte != SEQ_TAG)
                    phase_next = PH_SKIP;
                else
                begin
                    window_next = {window_reg[15:0], data_byte};
                    phase_next  = PH_SEARCH;
                end
            end
            PH_SEARCH:
            begin
                if (win_hit)
                begin
                    count_next = '0;
                    phase_next = PH_COPY;
                end
                else
                    window_next = {window_reg[15:0], data_byte};
            end
            PH_COPY:
            begin
                if (last_key)
                    phase_next = PH_SKIP;
                else if (!end_of_cert)
                    count_next = count_reg + IDX_W'(1);
            end
            PH_SKIP:
            begin
            end
            default:
            begin
            end
        endcase
        // rearm on the final byte of every certificate
        if (end_of_cert)
        begin
            phase_next  = PH_FIRST;
            window_next = '0;
            count_next  = '0;
        end
    end

    // result decode
    always_comb
    begin
        res_valid      = 1'b0;
        res.has_key    = 1'b0;
        res.key_byte   = '0;
        res.key_index  = '0;
        res.status     = ST_PENDING;
        res.final_flag = 1'b0;
        unique case (phase_reg)
            PH_FIRST:
            begin
                if (data_byte != SEQ_TAG)
                begin
                    res_valid      = 1'b1;
                    res.status     = ST_INVALID;
                    res.final_flag = 1'b1;
                end
                else if (end_of_cert)
                begin
                    res_valid      = 1'b1;
                    res.status     = ST_NOTFOUND;
                    res.final_flag = 1'b1;
                end
            end
            PH_SEARCH:
            begin
                if (end_of_cert)
                begin
                    res_valid      = 1'b1;
                    res.status     = win_hit ? ST_TRUNC : ST_NOTFOUND;
                    res.final_flag = 1'b1;
                end
            end
            PH_COPY:
            begin
                res_valid     = 1'b1;
                res.has_key   = 1'b1;
                res.key_byte  = data_byte;
                res.key_index = count_reg;
                if (last_key)
                begin
                    res.status     = ST_FOUND;
                    res.final_flag = 1'b1;
                end
                else if (end_of_cert)
                begin
                    res.status     = ST_TRUNC;
                    res.final_flag = 1'b1;
                end
            end
            PH_SKIP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_cert |=> phase_reg == PH_FIRST && window_reg == '0 && count_reg == '0)
        else $error("block did not rearm after final byte");

    a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FIRST |-> window_reg == '0 && count_reg == '0)
        else $error("stale window or count at certificate start");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_COPY |-> {1'b0, count_reg} < 7'(KEY_BYTES))
        else $error("copy count beyond key length");

    a_key_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.has_key |-> phase_reg == PH_COPY)
        else $error("key byte emitted outside copy");

endmodule

`default_nettype wire

FILE: rtl/cpe_out_stage.sv
`default_nettype none

module cpe_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cpe_pkg::result_t   push_res,
    output logic                    space,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cpe_pkg::result_t        out_res
);
    import cpe_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // the stage frees up in the same cycle its transaction completes
    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (space)
            valid_next = push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (space && push)
            res_reg <= push_res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

FILE: rtl/cert_pubkey_extractor_top.sv
`default_nettype none

// Certificate public key extractor.
// Input channel (in_valid/in_ready): one DER certificate byte per transaction,
// end_of_cert set on the final byte of each certificate.
// Output channel (out_valid/out_ready): zero or one result per input byte:
// key bytes with their index while copying, plus a status (found, invalid
// start, not found, truncated); final_result marks a certificate's last result.
// Throughput: one byte per cycle unless the receiver stalls. The parser state
// updates on the accepting edge, which also loads the result into the output
// register. A byte that yields no result passes through without occupying it.
// When the receiver stalls with a result held, in_ready drops until that
// result is taken; in_ready follows out_ready combinationally through the
// single output register.
// Reset clears the parser to expect a new certificate and empties the output
// register. Every final byte rearms the parser for the next certificate.
module cert_pubkey_extractor_top #(
    parameter int KEY_BYTES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_cert,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             has_key_byte,
    output logic [7:0]       key_byte,
    output logic [5:0]       key_index,
    output logic [2:0]       status,
    output logic             final_result
);
    import cpe_pkg::*;

    logic    accept;
    logic    res_valid;
    logic    space;
    result_t res;
    result_t out_res;

    assign in_ready = space;
    assign accept   = in_valid && space;

    cpe_parse #(
        .KEY_BYTES (KEY_BYTES)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .end_of_cert (end_of_cert),
        .res_valid   (res_valid),
        .res         (res)
    );

    cpe_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_res  (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign has_key_byte = out_res.has_key;
    assign key_byte     = out_res.key_byte;
    assign key_index    = out_res.key_index;
    assign status       = 3'(out_res.status);
    assign final_result = out_res.final_flag;

endmodule

`default_nettype wire
